// File: src/mi_pkg.sv
// Shared constants, control structs and modular helpers for the modular inverse unit.
// No dependencies; every other file refers to it by scoped names.
package mi_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    // Commands from the sequencer to the coefficient unit (one active at a time)
    typedef struct packed {
        logic load;     // start of item: t0 = 0, t1 = 1 mod m
        logic clr;      // start of a division: product accumulator = 0
        logic dbl;      // accumulator = 2 * accumulator mod m
        logic add;      // accumulator = accumulator + t1 mod m
        logic upd;      // t0, t1 = t1, t0 - accumulator mod m
    } t_coef_ctl;

    // Completion status from the sequencer
    typedef struct packed {
        logic done;     // result ready this cycle
        logic unit_gcd; // gcd equals one
    } t_ctl_status;

    // (a + b) mod m for a, b < m
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH:0] sum;
        logic [WIDTH:0] red;
        sum = {1'b0, a} + {1'b0, b};
        red = sum - {1'b0, m};
        add_mod = (sum >= {1'b0, m}) ? red[WIDTH-1:0] : sum[WIDTH-1:0];
    endfunction

    // (a - b) mod m for a, b < m; the wrap of a - b + m lands below m
    function automatic logic [WIDTH-1:0] sub_mod(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] m);
        sub_mod = (a >= b) ? (a - b) : (a - b + m);
    endfunction

endpackage

// File: src/mi_coef_unit.sv
// Bezout coefficient unit: holds t0, t1 and the quotient-times-t1 accumulator.
// Depends on mi_pkg; driven by the sequencer in mi_euclid_ctl.
module mi_coef_unit (
    input  logic                     i_clk,
    input  mi_pkg::t_coef_ctl        i_ctl,
    input  logic [mi_pkg::WIDTH-1:0] i_mod,
    output logic [mi_pkg::WIDTH-1:0] o_t0
);

    logic [mi_pkg::WIDTH-1:0] r_t0, n_t0;
    logic [mi_pkg::WIDTH-1:0] r_t1, n_t1;
    logic [mi_pkg::WIDTH-1:0] r_acc, n_acc;

    // Apply one command per cycle; the accumulator builds q * t1 mod m MSB first
    always_comb begin
        n_t0  = r_t0;
        n_t1  = r_t1;
        n_acc = r_acc;
        if (i_ctl.load) begin
            n_t0 = '0;
            n_t1 = (i_mod == mi_pkg::WIDTH'(1)) ? '0 : mi_pkg::WIDTH'(1);
        end else if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.dbl) begin
            n_acc = mi_pkg::add_mod(r_acc, r_acc, i_mod);
        end else if (i_ctl.add) begin
            n_acc = mi_pkg::add_mod(r_acc, r_t1, i_mod);
        end else if (i_ctl.upd) begin
            n_t0 = r_t1;
            n_t1 = mi_pkg::sub_mod(r_t0, r_acc, i_mod);
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_t0  <= n_t0;
        r_t1  <= n_t1;
        r_acc <= n_acc;
    end

    assign o_t0 = r_t0;

endmodule

// File: src/mi_euclid_ctl.sv
// Euclid sequencer: remainder registers, bit-serial restoring division and the
// state machine that steps the coefficient unit. Depends on mi_pkg.
module mi_euclid_ctl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [mi_pkg::WIDTH-1:0] i_value,
    input  logic [mi_pkg::WIDTH-1:0] i_mod,
    input  logic                     i_out_busy,
    output mi_pkg::t_coef_ctl        o_coef,
    output mi_pkg::t_ctl_status      o_status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_NORM  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;

    localparam int W = mi_pkg::WIDTH;

    logic [2:0]              r_state, n_state;
    logic [W-1:0]            r_r0, n_r0;
    logic [W-1:0]            r_r1, n_r1;
    logic [W-1:0]            r_rem, n_rem;
    logic [W-1:0]            r_d, n_d;
    logic [mi_pkg::CNT_W-1:0] r_k, n_k;

    // Sequence one Euclid iteration per pass: check, normalize, divide, update
    always_comb begin
        n_state  = r_state;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_rem    = r_rem;
        n_d      = r_d;
        n_k      = r_k;
        o_coef   = '0;
        o_status = '0;
        o_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_r0        = i_mod;
                    n_r1        = i_value;
                    o_coef.load = 1'b1;
                    n_state     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_r1 == '0 || i_mod == '0) begin
                    if (!i_out_busy) begin
                        o_status.done     = 1'b1;
                        o_status.unit_gcd = (r_r0 == W'(1));
                        n_state           = ST_IDLE;
                    end
                end else begin
                    n_rem      = r_r0;
                    n_d        = r_r1;
                    n_k        = '0;
                    o_coef.clr = 1'b1;
                    n_state    = ST_NORM;
                end
            end
            ST_NORM: begin
                // shift the divisor up while it still fits under the remainder
                if (!r_d[W-1] && ({r_d, 1'b0} <= {1'b0, r_rem})) begin
                    n_d = {r_d[W-2:0], 1'b0};
                    n_k = r_k + mi_pkg::CNT_W'(1);
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_coef.dbl = 1'b1;
                if (r_rem >= r_d) begin
                    n_rem   = r_rem - r_d;
                    n_state = ST_ADD;
                end else if (r_k == '0) begin
                    n_state = ST_UPD;
                end else begin
                    n_k = r_k - mi_pkg::CNT_W'(1);
                    n_d = r_d >> 1;
                end
            end
            ST_ADD: begin
                o_coef.add = 1'b1;
                if (r_k == '0) begin
                    n_state = ST_UPD;
                end else begin
                    n_k     = r_k - mi_pkg::CNT_W'(1);
                    n_d     = r_d >> 1;
                    n_state = ST_DIV;
                end
            end
            ST_UPD: begin
                o_coef.upd = 1'b1;
                n_r0       = r_r1;
                n_r1       = r_rem;
                n_state    = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_rem <= n_rem;
        r_d   <= n_d;
        r_k   <= n_k;
    end

`ifndef ASSERT_OFF
    // division leaves a remainder below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_rem < r_r1))
        else $error("remainder not reduced below divisor");

    // the shifted divisor never becomes zero while dividing
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM || r_state == ST_DIV || r_state == ST_ADD) |-> (r_d != '0))
        else $error("divisor register cleared during division");

    // a completion is followed by a return to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.done |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after completion");
`endif

endmodule

// File: src/modular_inverse_unit.sv
// Channel     | dir | payload (low bit first)               | handshake
// s_axis      | in  | tdata: value[31:0]                     | s_axis_tvalid / s_axis_tready
// m_axis      | out | tdata: inverse[31:0]; tuser: exists    | m_axis_tvalid / m_axis_tready
// cfg         | in  | i_cfg_data: modulus[31:0]              | i_cfg_valid / o_cfg_ready
//
// One item at a time: the item is accepted, then each Euclid iteration runs a check,
// normalize steps that shift the divisor up, bit-serial division steps with an add for
// each set quotient bit, and an update; a final check completes the item.
// Reset (synchronous, active low) sets the modulus to 1 and empties the output register.
// The next item is taken while a result waits; a stalled output only holds completion.
// Top level; depends on mi_pkg, mi_coef_unit and mi_euclid_ctl.
module modular_inverse_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [mi_pkg::WIDTH-1:0] s_axis_tdata,   // value
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [mi_pkg::WIDTH-1:0] m_axis_tdata,   // inverse
    output logic                     m_axis_tuser,   // exists
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [mi_pkg::WIDTH-1:0] i_cfg_data      // modulus
);

    logic [mi_pkg::WIDTH-1:0] r_mod;
    logic [mi_pkg::WIDTH-1:0] r_out_inv;
    logic                     r_out_exists;
    logic                     r_out_valid;
    logic [mi_pkg::WIDTH-1:0] w_t0;
    logic                     w_out_busy;
    mi_pkg::t_coef_ctl        w_coef;
    mi_pkg::t_ctl_status      w_status;

    assign o_cfg_ready = 1'b1;
    assign w_out_busy  = r_out_valid && !m_axis_tready;

    mi_euclid_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_value    (s_axis_tdata),
        .i_mod      (r_mod),
        .i_out_busy (w_out_busy),
        .o_coef     (w_coef),
        .o_status   (w_status)
    );

    mi_coef_unit u_coef (
        .i_clk (i_clk),
        .i_ctl (w_coef),
        .i_mod (r_mod),
        .o_t0  (w_t0)
    );

    // Hold the modulus; take each config transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= mi_pkg::WIDTH'(1);
        end else if (i_cfg_valid) begin
            r_mod <= i_cfg_data;
        end
    end

    // Output register valid: set on completion, drop when the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_status.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_status.done) begin
            r_out_inv    <= w_status.unit_gcd ? w_t0 : '0;
            r_out_exists <= w_status.unit_gcd;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_inv;
    assign m_axis_tuser  = r_out_exists;

endmodule
